// ===== sv/bgtd_pkg.sv =====
// shared types, constants and curve tables for the battery gauge trend detector
`default_nettype none

package bgtd_pkg;

  // field widths
  localparam int PIN_W    = 12;
  localparam int RATIO_W  = 4;
  localparam int THR_W    = 10;
  localparam int FULL_W   = 14;
  localparam int CFG_W    = 14;
  localparam int MV_W     = 15;
  localparam int FINE_W   = 15;
  localparam int WHOLE_W  = 7;
  localparam int CLASS_W  = 2;
  localparam int STATUS_W = 2;

  // voltage history
  localparam int WINDOW = 20;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int DIFF_W = MV_W + 1;

  // serial multiplier: one ratio bit per step
  localparam int PROD_W    = MV_W + 1;
  localparam int MUL_STEPS = RATIO_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  // curve and serial divider
  localparam int CURVE_N   = 21;
  localparam int SEG_N     = CURVE_N - 1;
  localparam int SEG_W     = $clog2(CURVE_N);
  localparam int DV_W      = 9;
  localparam int SPAN_W    = 9;
  localparam int Q_W       = 11;
  localparam int NUM_W     = 19;
  localparam int DIV_CNT_W = $clog2(Q_W);
  localparam int SEG_RISE  = 5 * 256;

  localparam logic [MV_W-1:0]   TOP_MV       = MV_W'(4200);
  localparam logic [MV_W-1:0]   BOTTOM_MV    = MV_W'(3270);
  localparam logic [FINE_W-1:0] FULL_FINE    = FINE_W'(100 * 256);
  localparam logic [FINE_W-1:0] HALF_FINE    = FINE_W'(50 * 256);
  localparam logic [FINE_W-1:0] FIFTH_FINE   = FINE_W'(20 * 256);
  localparam logic [FINE_W:0]   ROUND_FINE   = (FINE_W + 1)'(128);

  // register reset values
  localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(3);
  localparam logic [THR_W-1:0]   RISE_RST  = THR_W'(20);
  localparam logic [THR_W-1:0]   FALL_RST  = THR_W'(20);
  localparam logic [FULL_W-1:0]  FULL_RST  = FULL_W'(4150);

  typedef enum logic [1:0] {
    REG_RATIO = 2'd0,
    REG_RISE  = 2'd1,
    REG_FALL  = 2'd2,
    REG_FULL  = 2'd3
  } reg_idx_t;

  typedef enum logic [CLASS_W-1:0] {
    LEVEL_HIGH = 2'd0,
    LEVEL_MID  = 2'd1,
    LEVEL_LOW  = 2'd2
  } level_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DETECT   = 2'd0,
    STATUS_CHARGING = 2'd1,
    STATUS_BATTERY  = 2'd2,
    STATUS_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SEG,
    ST_LOAD,
    ST_DIV,
    ST_FINE,
    ST_OUT
  } state_t;

  // lipo discharge curve, highest voltage first
  function automatic logic [MV_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
    logic [MV_W-1:0] mv;
    case (idx)
      5'd0:    mv = MV_W'(4200);
      5'd1:    mv = MV_W'(4150);
      5'd2:    mv = MV_W'(4110);
      5'd3:    mv = MV_W'(4080);
      5'd4:    mv = MV_W'(4020);
      5'd5:    mv = MV_W'(3980);
      5'd6:    mv = MV_W'(3950);
      5'd7:    mv = MV_W'(3910);
      5'd8:    mv = MV_W'(3870);
      5'd9:    mv = MV_W'(3850);
      5'd10:   mv = MV_W'(3840);
      5'd11:   mv = MV_W'(3820);
      5'd12:   mv = MV_W'(3800);
      5'd13:   mv = MV_W'(3790);
      5'd14:   mv = MV_W'(3770);
      5'd15:   mv = MV_W'(3750);
      5'd16:   mv = MV_W'(3730);
      5'd17:   mv = MV_W'(3710);
      5'd18:   mv = MV_W'(3690);
      5'd19:   mv = MV_W'(3610);
      5'd20:   mv = MV_W'(3270);
      default: mv = '0;
    endcase
    return mv;
  endfunction

  // percent falls by five per point, from 100 down to 0
  function automatic logic [WHOLE_W-1:0] curve_pct(input logic [SEG_W-1:0] idx);
    logic [WHOLE_W-1:0] pct;
    if (idx < SEG_W'(CURVE_N)) begin
      pct = WHOLE_W'(100 - 5 * int'(idx));
    end else begin
      pct = '0;
    end
    return pct;
  endfunction

endpackage

`default_nettype wire

// ===== sv/bgtd_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module bgtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/bgtd_mul.sv =====
// bit-serial pin times ratio multiplier with saturation
`default_nettype none

module bgtd_mul
  import bgtd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [PIN_W-1:0]   pin,
  input  wire logic [RATIO_W-1:0] ratio,
  output logic                    done,
  output logic      [MV_W-1:0]    product
);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    acc;
  logic [PROD_W-1:0]    mcand;
  logic [RATIO_W-1:0]   mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one ratio bit per cycle, lsb first
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= PROD_W'(pin);
      mplier <= ratio;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[PROD_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[RATIO_W-1:1]};
    end
  end

  assign product = acc[PROD_W-1] ? '1 : acc[MV_W-1:0];

endmodule

`default_nettype wire

// ===== sv/bgtd_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none

module bgtd_div
  import bgtd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [SPAN_W-1:0] span,
  output logic                   done,
  output logic      [Q_W-1:0]    quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SPAN_W-1:0]    rem;
  logic [SPAN_W-1:0]    divisor;
  logic [Q_W-1:0]       work;
  logic [SPAN_W:0]      trial;
  logic [SPAN_W:0]      trial_sub;
  logic                 fits;

  // remainder stays below the divisor, so the trial fits one extra bit
  assign trial     = {rem, work[Q_W-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend bits leave the top of work, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= SPAN_W'(num[NUM_W-1:Q_W]);
      work    <= num[Q_W-1:0];
      divisor <= span;
    end else if (busy) begin
      rem  <= fits ? trial_sub[SPAN_W-1:0] : trial[SPAN_W-1:0];
      work <= {work[Q_W-2:0], fits};
    end
  end

  assign quot = work;

endmodule

`default_nettype wire

// ===== sv/battery_gauge_trend_detector.sv =====
// battery gauge top level: sequencer, voltage history and result register
`default_nettype none

// one request at a time: a new request is taken only once the result of the
//   last is loaded, after the 4-step serial multiply and the 11-step serial
//   divide of the curve interpolation
// the result register frees the sequencer while a result waits downstream
// reset: synchronous, clears sequencer, history fill and config to defaults;
//   history ram is not cleared, its stale entries only feed a DETECT status

module battery_gauge_trend_detector
  import bgtd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // sample request channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [PIN_W-1:0]    pin_millivolts,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [MV_W-1:0]     battery_mv,
  output logic      [FINE_W-1:0]   percent_fine,
  output logic      [WHOLE_W-1:0]  percent_whole,
  output logic      [CLASS_W-1:0]  level_class,
  output logic      [STATUS_W-1:0] charge_status,
  // config write port
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data
);

  // config registers
  logic [RATIO_W-1:0] divider_ratio;
  logic [THR_W-1:0]   rise_threshold_mv;
  logic [THR_W-1:0]   fall_threshold_mv;
  logic [FULL_W-1:0]  full_level_mv;

  // sequencer
  state_t state, state_next;
  logic   accept;
  logic   mul_start, mul_done;
  logic   div_start, div_done;
  logic   hist_we;
  logic   load_out;

  // datapath
  logic [MV_W-1:0]   batt;
  logic [MV_W-1:0]   oldest;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] read_slot;
  logic [FILL_W-1:0] fill_count;
  logic [SEG_W-1:0]  seg_sel;
  logic [SEG_W-1:0]  seg_idx;
  logic              clamp_hi;
  logic              clamp_lo;
  logic [DIFF_W-1:0] diff;
  logic [MV_W-1:0]   lo_mv;
  logic [MV_W-1:0]   dv_full;
  logic [DV_W-1:0]   dv;
  logic [NUM_W-1:0]  num;
  logic [SPAN_W-1:0] span;
  logic [Q_W-1:0]    quot;
  logic [FINE_W-1:0] fine;
  logic [FINE_W-1:0] fine_next;
  logic [FINE_W:0]   whole_sum;
  level_t            level_next;
  status_t           status_next;

  assign accept = in_valid && in_ready;

  // config writes, values masked to register width
  always_ff @(posedge clk) begin
    if (rst) begin
      divider_ratio     <= RATIO_RST;
      rise_threshold_mv <= RISE_RST;
      fall_threshold_mv <= FALL_RST;
      full_level_mv     <= FULL_RST;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_RATIO: divider_ratio     <= cfg_data[RATIO_W-1:0];
        REG_RISE:  rise_threshold_mv <= cfg_data[THR_W-1:0];
        REG_FALL:  fall_threshold_mv <= cfg_data[THR_W-1:0];
        REG_FULL:  full_level_mv     <= cfg_data[FULL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL;
      ST_MUL:  if (mul_done) state_next = ST_SEG;
      ST_SEG:  state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_FINE;
      ST_FINE: state_next = ST_OUT;
      ST_OUT:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    hist_we   = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        mul_start = in_valid;
      end
      ST_MUL:  hist_we   = mul_done;
      ST_LOAD: div_start = 1'b1;
      ST_OUT:  load_out  = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------
  // battery voltage: pin reading times divider ratio, bit serial
  // ---------------------------------------------------------------------
  bgtd_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .pin     (pin_millivolts),
    .ratio   (divider_ratio),
    .done    (mul_done),
    .product (batt)
  );

  // ---------------------------------------------------------------------
  // voltage history: the slot past the write slot holds the oldest sample
  // kept, read it at request time, write the new voltage once it is known
  // ---------------------------------------------------------------------
  assign read_slot = (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;

  bgtd_ram #(
    .WIDTH (MV_W),
    .DEPTH (WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (write_slot),
    .wdata (batt),
    .re    (accept),
    .raddr (read_slot),
    .rdata (oldest)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (hist_we) begin
      write_slot <= read_slot;
      if (fill_count != FILL_W'(WINDOW)) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // curve segment search: lower points fall monotonically, so the first
  // point at or below the voltage closes the segment
  // ---------------------------------------------------------------------
  always_comb begin
    seg_sel = '0;
    for (int i = SEG_N - 1; i >= 0; i--) begin
      if (batt >= curve_mv(SEG_W'(i + 1))) begin
        seg_sel = SEG_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEG) begin
      seg_idx  <= seg_sel;
      clamp_hi <= batt >= TOP_MV;
      clamp_lo <= batt <= BOTTOM_MV;
      diff     <= {1'b0, batt} - {1'b0, oldest};
    end
  end

  // interpolation numerator and segment span for the divider
  assign lo_mv   = curve_mv(seg_idx + 1'b1);
  assign dv_full = batt - lo_mv;
  assign dv      = (clamp_hi || clamp_lo) ? '0 : dv_full[DV_W-1:0];
  assign num     = NUM_W'(dv) * NUM_W'(SEG_RISE);
  assign span    = SPAN_W'(curve_mv(seg_idx) - lo_mv);

  bgtd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .span  (span),
    .done  (div_done),
    .quot  (quot)
  );

  // percent in 1/256 units, clamped at both ends of the curve
  always_comb begin
    if (clamp_hi) begin
      fine_next = FULL_FINE;
    end else if (clamp_lo) begin
      fine_next = '0;
    end else begin
      fine_next = FINE_W'({curve_pct(seg_idx + 1'b1), 8'h00}) + FINE_W'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINE) begin
      fine <= fine_next;
    end
  end

  // ---------------------------------------------------------------------
  // rounding, level class and charge status
  // ---------------------------------------------------------------------
  assign whole_sum = {1'b0, fine} + ROUND_FINE;

  always_comb begin
    if (fine > HALF_FINE) begin
      level_next = LEVEL_HIGH;
    end else if (fine > FIFTH_FINE) begin
      level_next = LEVEL_MID;
    end else begin
      level_next = LEVEL_LOW;
    end
  end

  // detect until full; then window change first, then the flat full level
  always_comb begin
    if (fill_count != FILL_W'(WINDOW)) begin
      status_next = STATUS_DETECT;
    end else if ($signed(diff) > $signed(DIFF_W'(rise_threshold_mv))) begin
      status_next = STATUS_CHARGING;
    end else if ($signed(diff) < -$signed(DIFF_W'(fall_threshold_mv))) begin
      status_next = STATUS_BATTERY;
    end else if (batt >= MV_W'(full_level_mv)) begin
      status_next = STATUS_FULL;
    end else begin
      status_next = STATUS_BATTERY;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      battery_mv    <= batt;
      percent_fine  <= fine;
      percent_whole <= whole_sum[FINE_W-1:8];
      level_class   <= level_next;
      charge_status <= status_next;
    end
  end

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("request taken while another is in flight");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(WINDOW))
    else $error("history fill count past window");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot < SLOT_W'(WINDOW))
    else $error("history slot past window");

  a_status_needs_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (charge_status != STATUS_DETECT) |-> fill_count == FILL_W'(WINDOW))
    else $error("trend status before history is full");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_done, div_done, load_out}))
    else $error("serial units finished together");
`endif

endmodule

`default_nettype wire
